FILE: src/hrht_pkg.sv
package hrht_pkg;

    localparam int MAX_METHOD_LEN = 16;
    localparam int NUM_WORDS      = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URI     = 3'd1,
        PH_VERSION = 3'd2,
        PH_NAME    = 3'd3,
        PH_VALUE   = 3'd4,
        PH_BODY    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        K_METHOD  = 3'd0,
        K_URI     = 3'd1,
        K_VERSION = 3'd2,
        K_NAME    = 3'd3,
        K_VALUE   = 3'd4,
        K_DELIM   = 3'd5,
        K_BODY    = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        MC_GET    = 3'd0,
        MC_POST   = 3'd1,
        MC_PUT    = 3'd2,
        MC_DELETE = 3'd3,
        MC_OTHER  = 3'd4
    } method_code_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [2:0] field_kind;
        logic [7:0] out_byte;
        logic       field_end;
        logic [2:0] method_code;
        logic       header_error;
        logic       message_end;
    } out_word_t;

    function automatic logic [4:0] word_len(input logic [1:0] k);
        logic [4:0] len;
        case (k)
            2'd0:    len = 5'd3;
            2'd1:    len = 5'd4;
            2'd2:    len = 5'd3;
            2'd3:    len = 5'd6;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Lowercase letters of get, post, put, delete.
    function automatic logic [7:0] word_char(input logic [1:0] k, input logic [4:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0: begin
                case (p)
                    5'd0:    c = 8'h67;
                    5'd1:    c = 8'h65;
                    5'd2:    c = 8'h74;
                    default: c = 8'h00;
                endcase
            end
            2'd1: begin
                case (p)
                    5'd0:    c = 8'h70;
                    5'd1:    c = 8'h6F;
                    5'd2:    c = 8'h73;
                    5'd3:    c = 8'h74;
                    default: c = 8'h00;
                endcase
            end
            2'd2: begin
                case (p)
                    5'd0:    c = 8'h70;
                    5'd1:    c = 8'h75;
                    5'd2:    c = 8'h74;
                    default: c = 8'h00;
                endcase
            end
            2'd3: begin
                case (p)
                    5'd0:    c = 8'h64;
                    5'd1:    c = 8'h65;
                    5'd2:    c = 8'h6C;
                    5'd3:    c = 8'h65;
                    5'd4:    c = 8'h74;
                    5'd5:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: src/http_request_head_tokenizer_core.sv
// HTTP request head tokenizer: takes one byte of request text per word and
// returns one tagged word per byte (field kind, the byte, end-of-field mark,
// method code on the byte that ends the method, header error, message end).
// A byte is accepted every cycle while the output is drained; its result
// is captured in the output register on acceptance, and input stalls
// only while that register is full and m_ready is low. Methods get,
// post, put and delete are matched without regard to case; anything else,
// or any method longer than MAX_METHOD_LEN bytes (16 by default), reports
// code 4. A zero byte or the end_of_message bit closes the message and
// returns the parser to reset.
module http_request_head_tokenizer_core #(
    parameter int MAX_METHOD_LEN = hrht_pkg::MAX_METHOD_LEN
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrht_pkg::in_word_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output hrht_pkg::out_word_t m_payload
);
    import hrht_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [4:0] mlen_reg, mlen_next;
    logic [3:0] mask_reg, mask_next;
    logic       line_start_reg, line_start_next;
    logic       name_nonempty_reg, name_nonempty_next;

    logic       m_valid_reg;
    out_word_t  out_reg, out_next;

    logic [4:0] mm_len;
    logic [3:0] mm_mask;
    logic [2:0] mm_code;
    logic       accept;
    logic [7:0] b;
    logic       eom;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;
    assign b         = s_payload.data_byte;

    hrht_method_match #(
        .MAX_METHOD_LEN (MAX_METHOD_LEN)
    ) u_method (
        .data_byte   (b),
        .length_cur  (mlen_reg),
        .mask_cur    (mask_reg),
        .length_next (mm_len),
        .mask_next   (mm_mask),
        .method_code (mm_code)
    );

    always_comb begin
        phase_next         = phase_reg;
        mlen_next          = mlen_reg;
        mask_next          = mask_reg;
        line_start_next    = line_start_reg;
        name_nonempty_next = name_nonempty_reg;
        eom                = s_payload.end_of_message;

        out_next.field_kind   = K_DELIM;
        out_next.out_byte     = b;
        out_next.field_end    = 1'b0;
        out_next.method_code  = MC_GET;
        out_next.header_error = 1'b0;
        out_next.message_end  = 1'b0;

        if (b == CH_NUL) begin
            out_next.field_end = 1'b1;
            if (phase_reg == PH_METHOD) begin
                out_next.method_code = mm_code;
            end
            eom = 1'b1;
        end else begin
            case (phase_reg)
                PH_METHOD: begin
                    if (b == CH_SPACE || b == CH_NL) begin
                        out_next.field_end   = 1'b1;
                        out_next.method_code = mm_code;
                        if (b == CH_SPACE) begin
                            phase_next = PH_URI;
                        end else begin
                            phase_next         = PH_NAME;
                            line_start_next    = 1'b1;
                            name_nonempty_next = 1'b0;
                        end
                    end else begin
                        out_next.field_kind = K_METHOD;
                        mlen_next           = mm_len;
                        mask_next           = mm_mask;
                    end
                end
                PH_URI, PH_VERSION: begin
                    if (b == CH_SPACE) begin
                        out_next.field_end = 1'b1;
                        phase_next         = PH_VERSION;
                    end else if (b == CH_NL) begin
                        out_next.field_end = 1'b1;
                        phase_next         = PH_NAME;
                        line_start_next    = 1'b1;
                        name_nonempty_next = 1'b0;
                    end else begin
                        out_next.field_kind = (phase_reg == PH_URI) ? K_URI : K_VERSION;
                    end
                end
                PH_NAME: begin
                    if (b == CH_NL) begin
                        out_next.field_end = 1'b1;
                        if (line_start_reg) begin
                            phase_next      = PH_BODY;
                            line_start_next = 1'b0;
                        end else begin
                            out_next.header_error = name_nonempty_reg;
                            phase_next            = PH_NAME;
                            line_start_next       = 1'b1;
                            name_nonempty_next    = 1'b0;
                        end
                    end else if (b == CH_COLON) begin
                        out_next.field_end = name_nonempty_reg;
                        phase_next         = PH_VALUE;
                        line_start_next    = 1'b0;
                        name_nonempty_next = 1'b0;
                    end else begin
                        out_next.field_kind = K_NAME;
                        line_start_next     = 1'b0;
                        name_nonempty_next  = 1'b1;
                    end
                end
                PH_VALUE: begin
                    if (b == CH_NL) begin
                        out_next.field_end = 1'b1;
                        phase_next         = PH_NAME;
                        line_start_next    = 1'b1;
                        name_nonempty_next = 1'b0;
                    end else begin
                        out_next.field_kind = K_VALUE;
                    end
                end
                default: begin
                    out_next.field_kind = K_BODY;
                end
            endcase
        end

        if (eom) begin
            out_next.message_end = 1'b1;
            phase_next           = PH_METHOD;
            mlen_next            = 5'd0;
            mask_next            = 4'hF;
            line_start_next      = 1'b0;
            name_nonempty_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_METHOD;
            mlen_reg          <= 5'd0;
            mask_reg          <= 4'hF;
            line_start_reg    <= 1'b0;
            name_nonempty_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg         <= phase_next;
                mlen_reg          <= mlen_next;
                mask_reg          <= mask_next;
                line_start_reg    <= line_start_next;
                name_nonempty_reg <= name_nonempty_next;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: src/hrht_method_match.sv
module hrht_method_match #(
    parameter int MAX_METHOD_LEN = hrht_pkg::MAX_METHOD_LEN
) (
    input  logic [7:0] data_byte,
    input  logic [4:0] length_cur,
    input  logic [3:0] mask_cur,
    output logic [4:0] length_next,
    output logic [3:0] mask_next,
    output logic [2:0] method_code
);
    import hrht_pkg::*;

    logic [7:0] lower_byte;

    always_comb begin
        if (data_byte >= 8'h41 && data_byte <= 8'h5A) begin
            lower_byte = data_byte + 8'd32;
        end else begin
            lower_byte = data_byte;
        end
    end

    always_comb begin
        mask_next = mask_cur;
        for (int k = 0; k < NUM_WORDS; k++) begin
            if (length_cur >= word_len(2'(k)) ||
                lower_byte != word_char(2'(k), length_cur)) begin
                mask_next[k] = 1'b0;
            end
        end
        length_next = (length_cur == 5'd31) ? length_cur : length_cur + 5'd1;
    end

    // Code of the method seen so far, first matching word wins.
    always_comb begin
        method_code = MC_OTHER;
        if (length_cur <= 5'(MAX_METHOD_LEN)) begin
            for (int k = NUM_WORDS - 1; k >= 0; k--) begin
                if (mask_cur[k] && length_cur == word_len(2'(k))) begin
                    method_code = 3'(k);
                end
            end
        end
    end

endmodule
